// ===== hdl/udrb_pkg.sv =====
// ----------------------------------------------------------------------------
// udrb_pkg
// Shared types and constants for the dual uart ring buffer
// ----------------------------------------------------------------------------
package udrb_pkg;

    // event kinds carried on the input tuser
    typedef enum logic [1:0] {
        MODE_IRQ   = 2'd0,
        MODE_GET   = 2'd1,
        MODE_PUT   = 2'd2,
        MODE_CLEAR = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_LOAD = 2'd2
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic latch;   // capture the input transfer
        logic exec;    // update pointers, access the rings
        logic load;    // fill the output register
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;  // output register empty or being taken this cycle
    } t_ctrl_stat;

    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;

    // input tdata bit positions
    localparam int IN_RX_READY = 0;
    localparam int IN_OVERRUN  = 1;
    localparam int IN_FRAMING  = 2;
    localparam int IN_TX_EMPTY = 3;
    localparam int IN_BYTE_LO  = 4;

    // output tdata bit positions
    localparam int OUT_SUCCESS   = 0;
    localparam int OUT_READ_LO   = 1;
    localparam int OUT_SEND_VAL  = 9;
    localparam int OUT_SEND_LO   = 10;
    localparam int OUT_OVERFLOW  = 18;
    localparam int OUT_IRQ_EN    = 19;
    localparam int OUT_USED_W    = 20;

endpackage

// ===== hdl/udrb_ctrl.sv =====
// ----------------------------------------------------------------------------
// udrb_ctrl
// Sequencer: takes one event, runs it, then loads the result register
// ----------------------------------------------------------------------------
module udrb_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  udrb_pkg::t_ctrl_stat  i_stat,
    output logic                  o_in_ready,
    output udrb_pkg::t_ctrl_cmd   o_cmd
);

    udrb_pkg::t_state r_state;
    udrb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= udrb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            udrb_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = udrb_pkg::ST_EXEC;
                end
            end
            udrb_pkg::ST_EXEC: begin
                n_state = udrb_pkg::ST_LOAD;
            end
            udrb_pkg::ST_LOAD: begin
                if (i_stat.out_free) begin
                    n_state = udrb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = udrb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            udrb_pkg::ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            udrb_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            udrb_pkg::ST_LOAD: begin
                o_cmd.load = i_stat.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/udrb_datapath.sv =====
// ----------------------------------------------------------------------------
// udrb_datapath
// Ring pointers, receive and transmit stores, and the result register
// ----------------------------------------------------------------------------
module udrb_datapath #(
    parameter int RX_DEPTH = 128,
    parameter int TX_DEPTH = 128
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  udrb_pkg::t_ctrl_cmd                i_cmd,
    output udrb_pkg::t_ctrl_stat               o_stat,
    input  logic [udrb_pkg::IN_DATA_W-1:0]     i_in_data,
    input  logic [udrb_pkg::IN_USER_W-1:0]     i_in_user,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [udrb_pkg::OUT_DATA_W-1:0]    o_out_data
);

    localparam int RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

    // captured event
    udrb_pkg::t_mode r_mode;
    logic            r_rx_ready;
    logic            r_overrun;
    logic            r_framing;
    logic            r_tx_empty;
    logic [7:0]      r_byte;

    logic [RX_AW-1:0] r_rx_wp, r_rx_rp, n_rx_wp, n_rx_rp;
    logic [TX_AW-1:0] r_tx_wp, r_tx_rp, n_tx_wp, n_tx_rp;
    logic             r_irq_en, n_irq_en;

    logic [7:0] r_rx_mem [RX_DEPTH];
    logic [7:0] r_tx_mem [TX_DEPTH];
    logic [7:0] r_rx_rdata;
    logic [7:0] r_tx_rdata;

    // per-event result flags, valid from exec to load
    logic r_res_success, n_res_success;
    logic r_res_send, n_res_send;
    logic r_res_ovf, n_res_ovf;
    logic r_res_get;

    logic                           r_out_valid;
    logic [udrb_pkg::OUT_DATA_W-1:0] r_out_data;
    logic [udrb_pkg::OUT_DATA_W-1:0] n_out_data;

    logic [RX_AW-1:0] rx_wp_inc, rx_rp_inc;
    logic [TX_AW-1:0] tx_wp_inc, tx_rp_inc;
    logic rx_hit, rx_full, rx_empty, tx_full, tx_ring_empty;
    logic rx_wr, rx_rd, tx_wr, tx_rd;

    assign rx_wp_inc     = r_rx_wp + 1'b1;
    assign rx_rp_inc     = r_rx_rp + 1'b1;
    assign tx_wp_inc     = r_tx_wp + 1'b1;
    assign tx_rp_inc     = r_tx_rp + 1'b1;
    assign rx_hit        = (r_rx_ready | r_overrun) & ~r_framing;
    assign rx_full       = (rx_wp_inc == r_rx_rp);
    assign rx_empty      = (r_rx_wp == r_rx_rp);
    assign tx_full       = (tx_wp_inc == r_tx_rp);
    assign tx_ring_empty = (r_tx_wp == r_tx_rp);

    always_comb begin
        n_rx_wp       = r_rx_wp;
        n_rx_rp       = r_rx_rp;
        n_tx_wp       = r_tx_wp;
        n_tx_rp       = r_tx_rp;
        n_irq_en      = r_irq_en;
        n_res_success = 1'b0;
        n_res_send    = 1'b0;
        n_res_ovf     = 1'b0;
        rx_wr         = 1'b0;
        rx_rd         = 1'b0;
        tx_wr         = 1'b0;
        tx_rd         = 1'b0;
        unique case (r_mode)
            udrb_pkg::MODE_IRQ: begin
                if (rx_hit && rx_full) begin
                    // receive overflow wipes both rings; tx side then sees empty
                    n_rx_wp   = '0;
                    n_rx_rp   = '0;
                    n_tx_wp   = '0;
                    n_tx_rp   = '0;
                    n_irq_en  = 1'b0;
                    n_res_ovf = 1'b1;
                end else begin
                    if (rx_hit) begin
                        n_rx_wp = rx_wp_inc;
                        rx_wr   = 1'b1;
                    end
                    if (r_tx_empty) begin
                        if (!tx_ring_empty) begin
                            n_tx_rp    = tx_rp_inc;
                            tx_rd      = 1'b1;
                            n_res_send = 1'b1;
                        end else begin
                            n_irq_en = 1'b0;
                        end
                    end
                end
            end
            udrb_pkg::MODE_GET: begin
                if (!rx_empty) begin
                    n_rx_rp       = rx_rp_inc;
                    rx_rd         = 1'b1;
                    n_res_success = 1'b1;
                end
            end
            udrb_pkg::MODE_PUT: begin
                if (!tx_full) begin
                    n_tx_wp       = tx_wp_inc;
                    tx_wr         = 1'b1;
                    n_irq_en      = 1'b1;
                    n_res_success = 1'b1;
                end
            end
            udrb_pkg::MODE_CLEAR: begin
                n_rx_rp = r_rx_wp;
            end
            default: begin
                n_rx_rp = r_rx_rp;
            end
        endcase
    end

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode     <= udrb_pkg::t_mode'(i_in_user);
            r_rx_ready <= i_in_data[udrb_pkg::IN_RX_READY];
            r_overrun  <= i_in_data[udrb_pkg::IN_OVERRUN];
            r_framing  <= i_in_data[udrb_pkg::IN_FRAMING];
            r_tx_empty <= i_in_data[udrb_pkg::IN_TX_EMPTY];
            r_byte     <= i_in_data[udrb_pkg::IN_BYTE_LO +: 8];
        end
    end

    // pointers and enable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_wp  <= '0;
            r_rx_rp  <= '0;
            r_tx_wp  <= '0;
            r_tx_rp  <= '0;
            r_irq_en <= 1'b0;
        end else if (i_cmd.exec) begin
            r_rx_wp  <= n_rx_wp;
            r_rx_rp  <= n_rx_rp;
            r_tx_wp  <= n_tx_wp;
            r_tx_rp  <= n_tx_rp;
            r_irq_en <= n_irq_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res_success <= n_res_success;
            r_res_send    <= n_res_send;
            r_res_ovf     <= n_res_ovf;
            r_res_get     <= rx_rd;
        end
    end

    // receive store
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && rx_wr) begin
            r_rx_mem[rx_wp_inc] <= r_byte;
        end
        if (i_cmd.exec && rx_rd) begin
            r_rx_rdata <= r_rx_mem[rx_rp_inc];
        end
    end

    // transmit store
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && tx_wr) begin
            r_tx_mem[tx_wp_inc] <= r_byte;
        end
        if (i_cmd.exec && tx_rd) begin
            r_tx_rdata <= r_tx_mem[tx_rp_inc];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        n_out_data = '0;
        n_out_data[udrb_pkg::OUT_SUCCESS]      = r_res_success;
        n_out_data[udrb_pkg::OUT_READ_LO +: 8] = r_res_get ? r_rx_rdata : 8'd0;
        n_out_data[udrb_pkg::OUT_SEND_VAL]     = r_res_send;
        n_out_data[udrb_pkg::OUT_SEND_LO +: 8] = r_res_send ? r_tx_rdata : 8'd0;
        n_out_data[udrb_pkg::OUT_OVERFLOW]     = r_res_ovf;
        n_out_data[udrb_pkg::OUT_IRQ_EN]       = r_irq_en;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_stat.out_free = ~r_out_valid | i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out_data;

endmodule

// ===== hdl/uart_dual_ring_buffer.sv =====
// ----------------------------------------------------------------------------
// uart_dual_ring_buffer
// Receive and transmit byte rings serving uart interrupt, get, put and clear
// ----------------------------------------------------------------------------
// channel   dir  handshake            payload
// s (event) in   i_s_tvalid/o_s_tready tuser: mode; tdata: status flags, byte
// m (result) out o_m_tvalid/i_m_tready tdata: success .. tx_irq_enabled
//
// an event runs through capture, ring access and result load in order; the
// store read is registered, so the result load follows the ring access
// a new event is taken as soon as the previous one has loaded the result
// register, while that result may still wait for its transfer
// a stalled output holds the sequencer in its load step
// synchronous active-low reset clears pointers, enable and handshake state;
// the stores are not cleared, entries are only read after being written
// ----------------------------------------------------------------------------
module uart_dual_ring_buffer #(
    parameter int RX_DEPTH = 128,
    parameter int TX_DEPTH = 128
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [0] rx_ready, [1] overrun, [2] framing_error, [3] tx_empty,
    // [11:4] byte_in, [15:12] zero
    input  logic [udrb_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // [1:0] mode
    input  logic [udrb_pkg::IN_USER_W-1:0]   i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [0] success, [8:1] read_byte, [9] send_valid, [17:10] send_byte,
    // [18] overflow_reset, [19] tx_irq_enabled, [23:20] zero
    output logic [udrb_pkg::OUT_DATA_W-1:0]  o_m_tdata
);

    udrb_pkg::t_ctrl_cmd  cmd;
    udrb_pkg::t_ctrl_stat stat;

    udrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_stat     (stat),
        .o_in_ready (o_s_tready),
        .o_cmd      (cmd)
    );

    udrb_datapath #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (i_s_tdata),
        .i_in_user   (i_s_tuser),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_out_data  (o_m_tdata)
    );

endmodule

// ===== hdl/udrb_checker.sv =====
// ----------------------------------------------------------------------------
// udrb_checker
// Port-level checks for the dual uart ring buffer, bound to the top level
// ----------------------------------------------------------------------------
module udrb_assertions (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [udrb_pkg::OUT_DATA_W-1:0]  o_m_tdata
);

    // a result waiting for its transfer does not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // one event in flight: no transfer in the cycle after a transfer
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("event taken while another is running");

    // no send byte without send flag
    a_send_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[udrb_pkg::OUT_SEND_VAL]
            |-> o_m_tdata[udrb_pkg::OUT_SEND_LO +: 8] == 8'd0)
        else $error("send byte set without send flag");

    // an overflow empties the transmit ring and drops the enable
    a_ovf_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[udrb_pkg::OUT_OVERFLOW]
            |-> !o_m_tdata[udrb_pkg::OUT_SEND_VAL] && !o_m_tdata[udrb_pkg::OUT_IRQ_EN]
                && !o_m_tdata[udrb_pkg::OUT_SUCCESS])
        else $error("overflow result with transmit activity");

endmodule

bind uart_dual_ring_buffer udrb_assertions u_udrb_assertions (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
